// ===== hdl/vipf_pkg.sv =====
// ----------------------------------------------------------------------------
// vipf_pkg
// Shared types and constants of the voxel isolated point filter.
// ----------------------------------------------------------------------------
package vipf_pkg;

  localparam int unsigned CoordBitsDef = 6;
  localparam int unsigned CountBits    = 24;
  localparam int unsigned NbrBits      = 5;
  localparam int unsigned NbrRows      = 9;
  localparam int unsigned StepBits     = 4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_REMOVAL_ENABLE = 2'd0;
  localparam logic [1:0] CFG_MIN_NEIGHBOURS = 2'd1;

  localparam logic [CountBits-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/vipf_ram.sv =====
// ----------------------------------------------------------------------------
// vipf_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vipf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/voxel_isolated_point_filter.sv =====
// ----------------------------------------------------------------------------
// voxel_isolated_point_filter
// 26-neighbour isolated point filter over an occupancy bitmap of voxel keys.
// ----------------------------------------------------------------------------
// The bitmap sits in one RAM with one row per (x, y) pair and one bit per z.
// A query reads its nine neighbouring rows one per cycle through the single
// read port and adds up to three bits of each row into the count. A valid
// query runs the scan state, then the done state, which loads the result
// register, and then returns to idle, where the next input is accepted. The
// load waits while the result register still holds an unaccepted result,
// and the input stalls with it. An invalid query with removal disabled
// skips the scan; an insert is a read-modify-write of one row; a dropped
// query, an invalid insert and an unused op do not leave the idle state.
// After reset and after each clear op, the block sweeps all 2^(2*COORD_BITS)
// RAM rows (4096 at the default) one row per cycle before it accepts an
// input transaction. Configuration writes are accepted at any time.
module voxel_isolated_point_filter
  import vipf_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic                         point_valid_i,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] vz_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         keep_o,
  output logic [NbrBits-1:0]           neighbour_count_o,
  output logic [CountBits-1:0]         removed_total_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [NbrBits-1:0]           cfg_data_i
);

  localparam int unsigned Side    = 1 << COORD_BITS;
  localparam int unsigned RowBits = 2 * COORD_BITS;
  localparam int unsigned Rows    = 1 << RowBits;

  state_e state_q, state_d;

  logic                  en_q;
  logic [NbrBits-1:0]    min_q;
  logic [COORD_BITS-1:0] x_q, y_q, z_q;
  logic [1:0]            dx_q, dy_q;
  logic [StepBits-1:0]   step_q;
  logic                  live_q, mid_q;
  logic [NbrBits-1:0]    cnt_q, cnt_d;
  logic [RowBits-1:0]    clr_q;
  logic [CountBits-1:0]  removed_q, removed_d;
  logic                  out_valid_q, keep_q, keep_d;
  logic [NbrBits-1:0]    out_cnt_q;
  logic [CountBits-1:0]  out_total_q;

  logic                  in_fire, cfg_fire, out_fire, load;
  logic                  re, we;
  logic [RowBits-1:0]    raddr, waddr;
  logic [Side-1:0]       wdata, rdata;
  logic [COORD_BITS:0]   nx, ny;
  logic                  in_range, issue;
  logic [COORD_BITS-1:0] z_lo, z_hi;
  logic                  b_lo, b_mid, b_hi;
  logic [1:0]            row_sum;

  assign in_fire  = in_valid_i & in_ready_o;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;
  assign out_fire = out_valid_q & out_ready_i;
  assign load     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign keep_o            = keep_q;
  assign neighbour_count_o = out_cnt_q;
  assign removed_total_o   = out_total_q;

  assign nx       = {1'b0, x_q} + (COORD_BITS + 1)'(dx_q) - (COORD_BITS + 1)'(1);
  assign ny       = {1'b0, y_q} + (COORD_BITS + 1)'(dy_q) - (COORD_BITS + 1)'(1);
  assign in_range = !nx[COORD_BITS] && !ny[COORD_BITS];
  assign issue    = (step_q < StepBits'(NbrRows)) && in_range;

  assign z_lo    = z_q - COORD_BITS'(1);
  assign z_hi    = z_q + COORD_BITS'(1);
  assign b_lo    = (z_q != '0) && rdata[z_lo];
  assign b_mid   = !mid_q && rdata[z_q];
  assign b_hi    = (z_q != '1) && rdata[z_hi];
  assign row_sum = 2'(b_lo) + 2'(b_mid) + 2'(b_hi);

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == ST_SCAN && step_q != '0 && live_q) begin
      cnt_d = cnt_q + NbrBits'(row_sum);
    end
  end

  always_comb begin
    keep_d    = !(en_q && (cnt_q < min_q));
    removed_d = removed_q;
    if (!keep_d && removed_q != COUNT_MAX) begin
      removed_d = removed_q + CountBits'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (op_i)
            OP_INSERT: state_d = point_valid_i ? ST_INS_RD : ST_IDLE;
            OP_QUERY: begin
              if (point_valid_i) begin
                state_d = ST_SCAN;
              end else if (en_q) begin
                state_d = ST_IDLE;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: state_d = ST_INS_WR;
      ST_INS_WR: state_d = ST_IDLE;
      ST_SCAN: begin
        if (step_q == StepBits'(NbrRows)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    re         = 1'b0;
    raddr      = {x_q, y_q};
    we         = 1'b0;
    waddr      = {x_q, y_q};
    wdata      = '0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      ST_IDLE:   in_ready_o = 1'b1;
      ST_INS_RD: re = 1'b1;
      ST_INS_WR: begin
        we    = 1'b1;
        wdata = rdata | (Side'(1) << z_q);
      end
      ST_SCAN: begin
        re    = issue;
        raddr = {nx[COORD_BITS-1:0], ny[COORD_BITS-1:0]};
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  vipf_ram #(
    .Width (Side),
    .Depth (Rows)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      en_q        <= 1'b1;
      min_q       <= NbrBits'(1);
      removed_q   <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      live_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_REMOVAL_ENABLE: en_q  <= cfg_data_i[0];
          CFG_MIN_NEIGHBOURS: min_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + RowBits'(1);
      end
      if (in_fire) begin
        step_q <= '0;
        live_q <= 1'b0;
        clr_q  <= '0;
        if (op_i == OP_CLEAR) begin
          removed_q <= '0;
        end
      end else if (state_q == ST_SCAN) begin
        step_q <= step_q + StepBits'(1);
        live_q <= issue;
      end
      if (load) begin
        removed_q <= removed_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= {~vx_i[COORD_BITS-1], vx_i[COORD_BITS-2:0]};
      y_q   <= {~vy_i[COORD_BITS-1], vy_i[COORD_BITS-2:0]};
      z_q   <= {~vz_i[COORD_BITS-1], vz_i[COORD_BITS-2:0]};
      dx_q  <= '0;
      dy_q  <= '0;
      cnt_q <= '0;
      mid_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      cnt_q <= cnt_d;
      mid_q <= (dx_q == 2'd1) && (dy_q == 2'd1);
      if (dy_q == 2'd2) begin
        dy_q <= '0;
        dx_q <= dx_q + 2'd1;
      end else begin
        dy_q <= dy_q + 2'd1;
      end
    end
    if (load) begin
      keep_q      <= keep_d;
      out_cnt_q   <= cnt_q;
      out_total_q <= removed_d;
    end
  end

`ifndef SYNTHESIS
  a_drop_below_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !keep_o |-> neighbour_count_o < min_q)
    else $error("removed point has a count at or above the minimum");

  a_drop_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !keep_o |-> removed_total_o != '0)
    else $error("removed point left the removed count at zero");

  a_count_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && op_i == OP_CLEAR) |=> removed_q >= $past(removed_q))
    else $error("removed count fell without a clear transaction");
`endif

endmodule
